/* hdl/gn2d_pkg.sv */
package gn2d_pkg;

	// Lattice and table geometry.
	localparam int MAX_SIZE_BITS = 8;
	localparam int TBL_AW        = MAX_SIZE_BITS;
	localparam int TBL_DEPTH     = 1 << TBL_AW;

	// Number of pipeline stages from the input register to the output register.
	localparam int NSTG = 13;

	// Width of a corner dot product and of each blend result (signed, Q.30).
	localparam int VW = 34;

	// Operation codes of a request.
	localparam logic [1:0] OP_EVAL  = 2'd0;
	localparam logic [1:0] OP_WGRAD = 2'd1;
	localparam logic [1:0] OP_WPERM = 2'd2;

	// Load enables of the three stages of one blend unit.
	typedef struct packed {
		logic d;
		logic p;
		logic v;
	} blend_en_t;

	// Wrap mask for a lattice of 2^n cells, with n clamped to the table size.
	function automatic logic [TBL_AW-1:0] wrap_mask(input logic [3:0] sb);
		logic [3:0]      sbc;
		logic [TBL_AW:0] one_hot;
		sbc     = (sb > 4'(MAX_SIZE_BITS)) ? 4'(MAX_SIZE_BITS) : sb;
		one_hot = (TBL_AW + 1)'(1) << sbc;
		return TBL_AW'(one_hot - (TBL_AW + 1)'(1));
	endfunction

endpackage

/* hdl/gn2d_blend.sv */
module gn2d_blend
	import gn2d_pkg::*;
(
	input  logic                 clk,
	input  blend_en_t            en,
	input  logic signed [VW-1:0] a,
	input  logic signed [VW-1:0] b,
	input  logic        [15:0]   w,
	output logic signed [VW-1:0] v
);

	// The product w * (a - b) is split at bit 16 of the difference so that each
	// partial multiply stays narrow; the low part only contributes its floor.
	logic signed [VW:0]    diff_s1;
	logic signed [VW-1:0]  a_s1;
	logic        [15:0]    w_s1;
	logic        [31:0]    plo_s2;
	logic signed [VW+1:0]  phi_s2;
	logic signed [VW-1:0]  a_s2;
	logic signed [VW-16:0] dhi;
	logic signed [VW+1:0]  step;

	assign dhi  = diff_s1[VW:16];
	assign step = phi_s2 + (VW + 2)'(plo_s2[31:16]);

	always_ff @(posedge clk) begin
		if (en.d) begin
			diff_s1 <= (VW + 1)'(a) - (VW + 1)'(b);
			a_s1    <= a;
			w_s1    <= w;
		end
		if (en.p) begin
			plo_s2 <= w_s1 * diff_s1[15:0];
			phi_s2 <= (VW + 2)'($signed({1'b0, w_s1}) * dhi);
			a_s2   <= a_s1;
		end
		if (en.v) begin
			v <= VW'((VW + 2)'(a_s2) - step);
		end
	end

endmodule

/* hdl/gradient_noise_2d_top.sv */
// Two-dimensional Perlin gradient noise at an unsigned Q16.16 position, with the
// result in signed Q1.14, saturated to [-16384, 16384]. Every request is either an
// evaluation or a write into the gradient table or the permutation table (256
// entries each); both tables must be loaded before an evaluation reads them, since
// an entry that was never written returns an arbitrary value. A request with
// operation code 3 is taken and dropped. The block is a 13-stage pipeline and takes
// one request per clock cycle, except while an output stall holds the input. Each table is held
// in more than one copy so that every copy is read at no more than two addresses per
// cycle; a write updates all copies as it passes the stage that reads them, so
// requests always see the tables in the order they were issued. A stall at the
// output holds the whole pipeline, empty stages are filled regardless, and no
// request is lost or repeated. The lattice size register may only be written while
// no request is in flight.
module gradient_noise_2d_top
	import gn2d_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic        [3:0]  cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic        [1:0]  operation,
	input  logic        [31:0] pos_x,
	input  logic        [31:0] pos_y,
	input  logic        [7:0]  table_index,
	input  logic signed [15:0] grad_x,
	input  logic signed [15:0] grad_y,
	input  logic        [7:0]  perm_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] noise_value
);

	logic [3:0]        lat_log2_q;
	logic [TBL_AW-1:0] mask;
	logic [NSTG:1]     vld_q;
	logic [NSTG+1:1]   adv;

	// Table copies: the first permutation copy serves the x lookup, the other two
	// copies serve the bottom and top rows of the second lookup, and the two gradient
	// copies serve the bottom and top rows of the corner fetch.
	logic [7:0]  perm_a_mem [TBL_DEPTH];
	logic [7:0]  perm_b_mem [TBL_DEPTH];
	logic [7:0]  perm_c_mem [TBL_DEPTH];
	logic [31:0] grad_a_mem [TBL_DEPTH];
	logic [31:0] grad_b_mem [TBL_DEPTH];

	// Stage 1: lattice coordinates, offsets and write fields.
	logic [1:0]        op_s1, op_s2, op_s3, op_s4;
	logic [TBL_AW-1:0] qx0_s1, qx1_s1, qy0_s1, qy1_s1;
	logic [TBL_AW-1:0] qy0_s2, qy1_s2;
	logic [TBL_AW-1:0] mask_s1, mask_s2;
	logic [15:0]       tx_s1, ty_s1, tx_s2, ty_s2, tx_s3, ty_s3, tx_s4, ty_s4;
	logic [TBL_AW-1:0] idx_s1, idx_s2, idx_s3;
	logic [31:0]       gent_s1, gent_s2, gent_s3;
	logic [7:0]        pv_s1, pv_s2;

	// Stage 2: x hashes. Stage 3: corner hashes. Stage 4: corner gradients.
	logic [7:0]        hx0_s2, hx1_s2;
	logic [7:0]        g00_s3, g01_s3, g10_s3, g11_s3;
	logic [31:0]       e00_s4, e01_s4, e10_s4, e11_s4;
	logic [TBL_AW-1:0] a00, a01, a10, a11;

	// Stage 5: partial dot products and smoothstep squares. Stage 6: dot products and weights.
	logic signed [32:0] p00x_s5, p00y_s5, p01x_s5, p01y_s5;
	logic signed [32:0] p10x_s5, p10y_s5, p11x_s5, p11y_s5;
	logic        [31:0] ttx_s5, tty_s5;
	logic        [17:0] cx_s5, cy_s5;
	logic signed [VW-1:0] v00_s6, v01_s6, v10_s6, v11_s6;
	logic        [49:0] pwx, pwy;
	logic        [15:0] wx_s6, wy_s6, wy_s7, wy_s8, wy_s9;

	// Blend outputs (bottom row and top row at stage 9, final value at stage 12).
	logic signed [VW-1:0] v0_s9, v1_s9, v_s12;
	logic signed [VW:0]   rsum;
	logic signed [18:0]   rnd;
	logic signed [15:0]   noise_s13;

	blend_en_t en_x, en_y;

	assign mask = wrap_mask(lat_log2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_log2_q <= 4'(MAX_SIZE_BITS);
		end else if (cfg_we) begin
			lat_log2_q <= cfg_wdata;
		end
	end

	// A stage loads when it is empty or when its contents move on this cycle.
	always_comb begin
		adv[NSTG+1] = !out_stall;
		for (int k = NSTG; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign in_stall  = !adv[1];
	assign out_valid = vld_q[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= in_valid && (operation == OP_EVAL || operation == OP_WGRAD ||
					operation == OP_WPERM);
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (adv[k]) begin
					// Table writes leave the pipeline once the last table has been updated.
					if (k == 5) begin
						vld_q[k] <= vld_q[k-1] && op_s4 == OP_EVAL;
					end else begin
						vld_q[k] <= vld_q[k-1];
					end
				end
			end
		end
	end

	// Corner hash addresses, wrapped to the lattice in use.
	assign a00 = (qy0_s2 + TBL_AW'(hx0_s2)) & mask_s2;
	assign a01 = (qy0_s2 + TBL_AW'(hx1_s2)) & mask_s2;
	assign a10 = (qy1_s2 + TBL_AW'(hx0_s2)) & mask_s2;
	assign a11 = (qy1_s2 + TBL_AW'(hx1_s2)) & mask_s2;

	// Each table copy is written at the stage that reads it, so an older evaluation
	// has already read it and a younger one has not yet.
	always_ff @(posedge clk) begin
		if (adv[2] && vld_q[1] && op_s1 == OP_WPERM) begin
			perm_a_mem[idx_s1] <= pv_s1;
		end
		if (adv[2]) begin
			hx0_s2 <= perm_a_mem[qx0_s1];
			hx1_s2 <= perm_a_mem[qx1_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[3] && vld_q[2] && op_s2 == OP_WPERM) begin
			perm_b_mem[idx_s2] <= pv_s2;
			perm_c_mem[idx_s2] <= pv_s2;
		end
		if (adv[3]) begin
			g00_s3 <= perm_b_mem[a00];
			g01_s3 <= perm_b_mem[a01];
			g10_s3 <= perm_c_mem[a10];
			g11_s3 <= perm_c_mem[a11];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4] && vld_q[3] && op_s3 == OP_WGRAD) begin
			grad_a_mem[idx_s3] <= gent_s3;
			grad_b_mem[idx_s3] <= gent_s3;
		end
		if (adv[4]) begin
			e00_s4 <= grad_a_mem[TBL_AW'(g00_s3)];
			e01_s4 <= grad_a_mem[TBL_AW'(g01_s3)];
			e10_s4 <= grad_b_mem[TBL_AW'(g10_s3)];
			e11_s4 <= grad_b_mem[TBL_AW'(g11_s3)];
		end
	end

	assign pwx = ttx_s5 * cx_s5;
	assign pwy = tty_s5 * cy_s5;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			op_s1   <= operation;
			mask_s1 <= mask;
			qx0_s1  <= pos_x[16 +: TBL_AW] & mask;
			qx1_s1  <= (pos_x[16 +: TBL_AW] + TBL_AW'(1)) & mask;
			qy0_s1  <= pos_y[16 +: TBL_AW] & mask;
			qy1_s1  <= (pos_y[16 +: TBL_AW] + TBL_AW'(1)) & mask;
			tx_s1   <= pos_x[15:0];
			ty_s1   <= pos_y[15:0];
			idx_s1  <= table_index[TBL_AW-1:0];
			gent_s1 <= {grad_y, grad_x};
			pv_s1   <= perm_value;
		end
		if (adv[2]) begin
			op_s2   <= op_s1;
			mask_s2 <= mask_s1;
			qy0_s2  <= qy0_s1;
			qy1_s2  <= qy1_s1;
			tx_s2   <= tx_s1;
			ty_s2   <= ty_s1;
			idx_s2  <= idx_s1;
			gent_s2 <= gent_s1;
			pv_s2   <= pv_s1;
		end
		if (adv[3]) begin
			op_s3   <= op_s2;
			tx_s3   <= tx_s2;
			ty_s3   <= ty_s2;
			idx_s3  <= idx_s2;
			gent_s3 <= gent_s2;
		end
		if (adv[4]) begin
			op_s4 <= op_s3;
			tx_s4 <= tx_s3;
			ty_s4 <= ty_s3;
		end
		if (adv[5]) begin
			// The far-side offset t - 1 in 17-bit two's complement is t with bit 16 set.
			p00x_s5 <= $signed(e00_s4[15:0])  * $signed({1'b0, tx_s4});
			p00y_s5 <= $signed(e00_s4[31:16]) * $signed({1'b0, ty_s4});
			p01x_s5 <= $signed(e01_s4[15:0])  * $signed({1'b1, tx_s4});
			p01y_s5 <= $signed(e01_s4[31:16]) * $signed({1'b0, ty_s4});
			p10x_s5 <= $signed(e10_s4[15:0])  * $signed({1'b0, tx_s4});
			p10y_s5 <= $signed(e10_s4[31:16]) * $signed({1'b1, ty_s4});
			p11x_s5 <= $signed(e11_s4[15:0])  * $signed({1'b1, tx_s4});
			p11y_s5 <= $signed(e11_s4[31:16]) * $signed({1'b1, ty_s4});
			ttx_s5  <= tx_s4 * tx_s4;
			tty_s5  <= ty_s4 * ty_s4;
			cx_s5   <= 18'd196608 - {1'b0, tx_s4, 1'b0};
			cy_s5   <= 18'd196608 - {1'b0, ty_s4, 1'b0};
		end
		if (adv[6]) begin
			v00_s6 <= VW'(p00x_s5) + VW'(p00y_s5);
			v01_s6 <= VW'(p01x_s5) + VW'(p01y_s5);
			v10_s6 <= VW'(p10x_s5) + VW'(p10y_s5);
			v11_s6 <= VW'(p11x_s5) + VW'(p11y_s5);
			wx_s6  <= pwx[47:32];
			wy_s6  <= pwy[47:32];
		end
		if (adv[7]) begin
			wy_s7 <= wy_s6;
		end
		if (adv[8]) begin
			wy_s8 <= wy_s7;
		end
		if (adv[9]) begin
			wy_s9 <= wy_s8;
		end
		if (adv[13]) begin
			if (rnd > 19'sd16384) begin
				noise_s13 <= 16'sd16384;
			end else if (rnd < -19'sd16384) begin
				noise_s13 <= -16'sd16384;
			end else begin
				noise_s13 <= 16'(rnd);
			end
		end
	end

	// Blend along x for the bottom and top rows, then along y.
	assign en_x = '{d: adv[7],  p: adv[8],  v: adv[9]};
	assign en_y = '{d: adv[10], p: adv[11], v: adv[12]};

	gn2d_blend u_blend_x0 (
		.clk (clk),
		.en  (en_x),
		.a   (v00_s6),
		.b   (v01_s6),
		.w   (wx_s6),
		.v   (v0_s9)
	);

	gn2d_blend u_blend_x1 (
		.clk (clk),
		.en  (en_x),
		.a   (v10_s6),
		.b   (v11_s6),
		.w   (wx_s6),
		.v   (v1_s9)
	);

	gn2d_blend u_blend_y (
		.clk (clk),
		.en  (en_y),
		.a   (v0_s9),
		.b   (v1_s9),
		.w   (wy_s9),
		.v   (v_s12)
	);

	// Round to Q1.14 with a floor after adding one half.
	assign rsum = (VW + 1)'(v_s12) + (VW + 1)'(32768);
	assign rnd  = rsum[VW:16];

	assign noise_value = noise_s13;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

// Self-checking bench for the 2D gradient noise pipeline. Requests are driven on the
// falling edge and results are sampled on the rising edge. A predictor holds its own copy
// of the gradient and permutation tables and of the lattice size register. Each evaluation
// pushes one expected noise value into a queue, and a checker pops that queue as results
// arrive.
module tb
	import gn2d_pkg::*;
();

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic        [3:0]  cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic        [1:0]  operation;
	logic        [31:0] pos_x;
	logic        [31:0] pos_y;
	logic        [7:0]  table_index;
	logic signed [15:0] grad_x;
	logic signed [15:0] grad_y;
	logic        [7:0]  perm_value;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] noise_value;

	gradient_noise_2d_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .operation(operation),
		.pos_x(pos_x), .pos_y(pos_y), .table_index(table_index),
		.grad_x(grad_x), .grad_y(grad_y), .perm_value(perm_value),
		.out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value)
	);

	// The predictor's copy of the block's state.
	logic [31:0]        grad_mem [TBL_DEPTH];
	logic [7:0]         perm_mem [TBL_DEPTH];
	logic [3:0]         lattice_bits;
	logic signed [15:0] noise_queue [$];

	int unsigned        mismatches;
	int unsigned        send_idle_pct;
	int unsigned        recv_idle_pct;
	int unsigned        hold_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Floor division by 2^16 on a signed value. An arithmetic shift already floors.
	function automatic longint floor16(input longint x);
		return x >>> 16;
	endfunction

	// The smoothstep weight t*t*(3-2t) in Q0.16, truncated.
	function automatic longint smoothstep_q16(input longint t);
		logic [63:0] prod;
		prod = 64'(t) * 64'(t) * 64'(196608 - 2 * t);
		return longint'(prod >> 32);
	endfunction

	function automatic longint corner_product(input logic [7:0] gi, input longint ox,
			input longint oy);
		logic signed [15:0] gx;
		logic signed [15:0] gy;
		gx = grad_mem[gi][15:0];
		gy = grad_mem[gi][31:16];
		return longint'(gx) * ox + longint'(gy) * oy;
	endfunction

	function automatic longint lerp_q16(input longint a, input longint b, input longint w);
		return a - floor16(w * (a - b));
	endfunction

	function automatic logic signed [15:0] noise_at(input logic [31:0] px,
			input logic [31:0] py);
		logic [7:0] m;
		logic [7:0] x0;
		logic [7:0] x1;
		logic [7:0] y0;
		logic [7:0] y1;
		logic [7:0] h0;
		logic [7:0] h1;
		longint tx;
		longint ty;
		longint v0;
		longint v1;
		longint wx;
		longint wy;
		longint r;
		m  = (lattice_bits >= 8) ? 8'hFF : 8'((9'd1 << lattice_bits) - 9'd1);
		x0 = px[23:16] & m;
		x1 = (x0 + 8'd1) & m;
		y0 = py[23:16] & m;
		y1 = (y0 + 8'd1) & m;
		tx = longint'(px[15:0]);
		ty = longint'(py[15:0]);
		h0 = perm_mem[x0];
		h1 = perm_mem[x1];
		wx = smoothstep_q16(tx);
		wy = smoothstep_q16(ty);
		v0 = lerp_q16(corner_product(perm_mem[(y0 + h0) & m], tx, ty),
			corner_product(perm_mem[(y0 + h1) & m], tx - 65536, ty), wx);
		v1 = lerp_q16(corner_product(perm_mem[(y1 + h0) & m], tx, ty - 65536),
			corner_product(perm_mem[(y1 + h1) & m], tx - 65536, ty - 65536), wx);
		r = floor16(lerp_q16(v0, v1, wy) + 32768);
		if (r > 16384)
			r = 16384;
		if (r < -16384)
			r = -16384;
		return 16'(r);
	endfunction

	// Offers one request and holds it until the block takes it. The predictor is updated
	// at the acceptance edge, so the order of expectations follows the order of requests.
	// Valid is only dropped while the sender idles or the bench drains.
	task automatic send_request(input logic [1:0] op, input logic [31:0] px,
			input logic [31:0] py, input logic [7:0] idx, input logic [15:0] gx,
			input logic [15:0] gy, input logic [7:0] pv);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		pos_x       <= px;
		pos_y       <= py;
		table_index <= idx;
		grad_x      <= gx;
		grad_y      <= gy;
		perm_value  <= pv;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		case (op)
			OP_EVAL:  noise_queue.push_back(noise_at(px, py));
			OP_WGRAD: grad_mem[idx] = {gy, gx};
			OP_WPERM: perm_mem[idx] = pv;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Waits until every expected result has come, then lets the pipeline drain.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (noise_queue.size() != 0)
			@(negedge clk);
		repeat (NSTG + 4)
			@(negedge clk);
	endtask

	// Writes the lattice size register. This is only called once the pipeline is empty.
	task automatic set_lattice_bits(input logic [3:0] sb);
		drain_pipeline();
		cfg_we    <= 1'b1;
		cfg_wdata <= sb;
		@(negedge clk);
		cfg_we       <= 1'b0;
		lattice_bits  = sb;
	endtask

	function automatic logic [15:0] random_grad();
		case ($urandom_range(7))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'h8000;
			3: return 16'($urandom);
			default: return 16'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	function automatic logic [31:0] random_pos();
		case ($urandom_range(5))
			0: return {16'($urandom), 16'h0000};
			1: return {16'($urandom), 16'hFFFF};
			default: return $urandom;
		endcase
	endfunction

	// Gives every table entry a defined value, so that no evaluation can read an entry
	// that was never written. Gradients are random, including the edge values.
	task automatic load_tables();
		int i;
		for (i = 0; i < TBL_DEPTH; i++) begin
			send_request(OP_WPERM, 0, 0, 8'(i), 0, 0, 8'($urandom));
			send_request(OP_WGRAD, 0, 0, 8'(i), random_grad(), random_grad(), 0);
		end
	endtask

	// The directed part covers the corners of the lattice cell, the extreme positions,
	// the strongest gradients and the unused operation code.
	task automatic test_directed();
		set_lattice_bits(4'd8);
		load_tables();
		send_request(OP_EVAL, 32'h0, 32'h0, 0, 0, 0, 0);
		send_request(OP_EVAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_request(OP_EVAL, 32'h0000_8000, 32'h0000_8000, 0, 0, 0, 0);
		send_request(OP_EVAL, 32'h0001_FFFF, 32'h0003_0000, 0, 0, 0, 0);
		send_request(OP_WGRAD, 0, 0, 8'd0, 16'h8000, 16'h8000, 0);
		send_request(OP_WGRAD, 0, 0, 8'd1, 16'sd16384, 16'sd16384, 0);
		send_request(OP_WGRAD, 0, 0, 8'd2, 16'h7FFF, 16'h7FFF, 0);
		send_request(OP_WPERM, 0, 0, 8'd0, 0, 0, 8'd0);
		send_request(OP_EVAL, 32'h0000_7FFF, 32'h0000_C000, 0, 0, 0, 0);
		send_request(OP_EVAL, 32'h00FF_4000, 32'hFF00_4000, 0, 0, 0, 0);
		send_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_request(OP_EVAL, 32'h0000_0001, 32'hFFFF_0001, 0, 0, 0, 0);
		// Size zero sends every lookup to entry zero, and large values clamp to eight.
		set_lattice_bits(4'd0);
		send_request(OP_EVAL, 32'h1234_5678, 32'h9ABC_DEF0, 0, 0, 0, 0);
		send_request(OP_EVAL, 32'hFFFF_FFFF, 32'h0000_0000, 0, 0, 0, 0);
		set_lattice_bits(4'd15);
		send_request(OP_EVAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0);
		send_request(OP_EVAL, 32'h0100_8000, 32'h0080_8000, 0, 0, 0, 0);
		set_lattice_bits(4'd1);
		send_request(OP_EVAL, 32'h0003_C000, 32'h0002_4000, 0, 0, 0, 0);
	endtask

	// Random traffic is mostly evaluations mixed with table writes and a few dropped
	// codes. Every table entry is already defined, so any index can be read.
	task automatic test_random(input int n, input logic [3:0] sb);
		int i;
		int k;
		set_lattice_bits(sb);
		for (i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 70)
				send_request(OP_EVAL, random_pos(), random_pos(), 8'($urandom),
					16'($urandom), 16'($urandom), 8'($urandom));
			else if (k < 84)
				send_request(OP_WGRAD, $urandom, $urandom, 8'($urandom), random_grad(),
					random_grad(), 8'($urandom));
			else if (k < 97)
				send_request(OP_WPERM, $urandom, $urandom, 8'($urandom), 16'($urandom),
					16'($urandom), 8'($urandom));
			else
				send_request(2'd3, $urandom, $urandom, 8'($urandom), 16'($urandom),
					16'($urandom), 8'($urandom));
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering
	// requests back to back, so the pipeline fills and stalls its input. The sender
	// then waits for every result and sends ten more evaluations.
	task automatic test_back_pressure();
		int i;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles = 60;
		for (i = 0; i < 40; i++)
			send_request(OP_EVAL, $urandom, $urandom, 0, 0, 0, 0);
		drain_pipeline();
		for (i = 0; i < 10; i++)
			send_request(OP_EVAL, random_pos(), random_pos(), 0, 0, 0, 0);
	endtask

	// The receiver's stall. A long hold-off is counted down here.
	always @(negedge clk) begin
		if (hold_cycles != 0) begin
			out_stall   <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Result checker. Each accepted result is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (noise_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected noise result %0d", noise_value);
			end else if (noise_value !== noise_queue[0]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("noise mismatch: expected %0d, got %0d", noise_queue[0],
						noise_value);
				void'(noise_queue.pop_front());
			end else begin
				void'(noise_queue.pop_front());
			end
		end
	end

	initial begin
		#20_000_000;
		$display("gradient_noise_2d_top test failed");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = 4'd0;
		in_valid      = 1'b0;
		out_stall     = 1'b0;
		operation     = OP_EVAL;
		pos_x         = '0;
		pos_y         = '0;
		table_index   = '0;
		grad_x        = '0;
		grad_y        = '0;
		perm_value    = '0;
		mismatches    = 0;
		hold_cycles   = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		lattice_bits  = 4'd8;
		repeat (9)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		send_idle_pct = 38;
		recv_idle_pct = 82;
		test_random(90, 4'd8);
		send_idle_pct = 82;
		recv_idle_pct = 38;
		test_random(90, 4'd3);
		test_back_pressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(90, 4'd5);
		drain_pipeline();

		if (mismatches == 0 && noise_queue.size() == 0)
			$display("gradient_noise_2d_top test passed");
		else
			$display("gradient_noise_2d_top test failed");
		$finish;
	end
endmodule

/* sim.f */
hdl/gn2d_pkg.sv
hdl/gn2d_blend.sv
hdl/gradient_noise_2d_top.sv
tb/tb.sv
